// File: sv/fihos_pkg.sv
`default_nettype none
package fihos_pkg;

	// configuration durations and ramp divider operands are all this wide
	localparam int DUR_BITS = 16;

	localparam logic [1:0] REG_FADE_IN  = 2'd0;
	localparam logic [1:0] REG_FADE_OUT = 2'd1;
	localparam logic [1:0] REG_HOLD     = 2'd2;

	typedef struct packed {
		logic                start;
		logic [DUR_BITS-1:0] num;
		logic [DUR_BITS-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

// File: sv/fade_in_hold_out_sequencer_top.sv
`default_nettype none
// Brightness fade sequencer: one request per display refresh carries a millisecond
// time stamp, and one result comes back for each with the new phase and, where the
// step sets one, a fade level in unsigned fixed point (2^LEVEL_FRAC_BITS = full).
// A request in the start, settle or hold phase, at a ramp end or in the done phase
// is answered in the cycle after it is taken. A request that falls inside a fade-in or
// fade-out ramp runs the shared restoring divider, one quotient bit a cycle, and its
// result is registered once the divider is done; no request is taken while the divider
// runs. A waiting result does not stop the next request from being taken as long as it
// is collected in the same cycle.
// Write the duration registers only while no request is in flight.
module fade_in_hold_out_sequencer_top import fihos_pkg::*; #(
	parameter int TIME_BITS       = 32,
	parameter int LEVEL_FRAC_BITS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DUR_BITS-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [31:0]         now_ms,
	input  wire logic                skip_hold,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     level_valid,
	output logic [15:0]              fade_level,
	output logic [2:0]               phase_now
);

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SETTLE = 3'd1;
	localparam logic [2:0] PH_IN     = 3'd2;
	localparam logic [2:0] PH_HOLD   = 3'd3;
	localparam logic [2:0] PH_OUT    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam int LVL_BITS = LEVEL_FRAC_BITS + 1;
	localparam logic [LVL_BITS-1:0] FULL_LEVEL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	logic [DUR_BITS-1:0]  fade_in_q;
	logic [DUR_BITS-1:0]  fade_out_q;
	logic [DUR_BITS-1:0]  hold_q;
	logic                 hold_cleared_q;

	logic [2:0]           phase_q;
	logic [TIME_BITS-1:0] last_stamp_q;
	logic [TIME_BITS-1:0] elapsed_q;

	logic                 busy_q;
	logic                 pend_valid_q;
	logic                 pend_invert_q;
	logic [2:0]           pend_phase_q;

	logic                 out_valid_q;
	logic                 level_valid_q;
	logic [15:0]          fade_level_q;
	logic [2:0]           phase_now_q;

	logic                 accept;
	logic                 taken;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] step;
	logic [TIME_BITS:0]   sum;
	logic [TIME_BITS-1:0] sat_sum;
	logic                 hc_eff;
	logic [DUR_BITS-1:0]  hold_eff;

	logic [2:0]           phase_d;
	logic [TIME_BITS-1:0] elapsed_d;
	logic                 stamp_upd;
	logic                 valid_d;
	logic [LVL_BITS-1:0]  level_d;
	logic                 need_div;
	logic                 invert_d;
	logic [DUR_BITS-1:0]  den_d;

	div_req_t             div_req;
	logic                 div_done;
	logic [LEVEL_FRAC_BITS-1:0] div_quot;
	logic [LVL_BITS-1:0]  ramp_level;

	assign taken    = out_valid_q & ~out_stall;
	assign in_stall = busy_q | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	assign now_t   = TIME_BITS'(now_ms);
	assign step    = now_t - last_stamp_q;
	assign sum     = {1'b0, elapsed_q} + {1'b0, step};
	assign sat_sum = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	assign hc_eff   = hold_cleared_q | skip_hold;
	assign hold_eff = hc_eff ? '0 : hold_q;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		stamp_upd = 1'b0;
		valid_d   = 1'b0;
		level_d   = '0;
		need_div  = 1'b0;
		invert_d  = 1'b0;
		den_d     = fade_in_q;
		case (phase_q)
			PH_START, PH_SETTLE: begin
				stamp_upd = 1'b1;
				valid_d   = fade_in_q != '0;
				elapsed_d = '0;
				phase_d   = (phase_q == PH_START) ? PH_SETTLE : PH_IN;
			end
			PH_IN: begin
				stamp_upd = 1'b1;
				valid_d   = 1'b1;
				if (elapsed_q < TIME_BITS'(fade_in_q)) begin
					need_div  = 1'b1;
					elapsed_d = sat_sum;
				end else begin
					level_d   = FULL_LEVEL;
					elapsed_d = '0;
					phase_d   = PH_HOLD;
				end
			end
			PH_HOLD: begin
				stamp_upd = 1'b1;
				if (elapsed_q < TIME_BITS'(hold_eff)) begin
					elapsed_d = sat_sum;
				end else begin
					elapsed_d = '0;
					phase_d   = PH_OUT;
				end
			end
			PH_OUT: begin
				stamp_upd = 1'b1;
				valid_d   = 1'b1;
				den_d     = fade_out_q;
				if (fade_out_q == '0) begin
					level_d   = FULL_LEVEL;
					elapsed_d = '0;
					phase_d   = PH_DONE;
				end else if (elapsed_q < TIME_BITS'(fade_out_q)) begin
					need_div  = 1'b1;
					invert_d  = 1'b1;
					elapsed_d = sat_sum;
				end else begin
					elapsed_d = '0;
					phase_d   = PH_DONE;
				end
			end
			default: begin
				// done and the unused codes hold everything
			end
		endcase
	end

	// elapsed is below the divisor here, so its low bits are the whole value
	assign div_req.start = accept & need_div;
	assign div_req.num   = elapsed_q[DUR_BITS-1:0];
	assign div_req.den   = den_d;

	fihos_div #(
		.FRAC_BITS (LEVEL_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign ramp_level = pend_invert_q ? (FULL_LEVEL - {1'b0, div_quot}) : {1'b0, div_quot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q      <= '0;
			fade_out_q     <= '0;
			hold_q         <= '0;
			hold_cleared_q <= 1'b0;
			phase_q        <= PH_START;
			last_stamp_q   <= '0;
			elapsed_q      <= '0;
			busy_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FADE_IN:  fade_in_q <= cfg_data;
					REG_FADE_OUT: fade_out_q <= cfg_data;
					REG_HOLD: begin
						hold_q         <= cfg_data;
						hold_cleared_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				hold_cleared_q <= hc_eff;
				phase_q        <= phase_d;
				elapsed_q      <= elapsed_d;
				if (stamp_upd) begin
					last_stamp_q <= now_t;
				end
			end
			if (accept & need_div) begin
				busy_q <= 1'b1;
			end else if (div_done) begin
				busy_q <= 1'b0;
			end
			if ((accept & ~need_div) | div_done) begin
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_valid_q  <= valid_d;
			pend_invert_q <= invert_d;
			pend_phase_q  <= phase_d;
		end
		if (accept & ~need_div) begin
			level_valid_q <= valid_d;
			fade_level_q  <= 16'(level_d);
			phase_now_q   <= phase_d;
		end else if (div_done) begin
			level_valid_q <= pend_valid_q;
			fade_level_q  <= 16'(ramp_level);
			phase_now_q   <= pend_phase_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign level_valid = level_valid_q;
	assign fade_level  = fade_level_q;
	assign phase_now   = phase_now_q;

endmodule
`default_nettype wire

// File: sv/fihos_div.sv
`default_nettype none
module fihos_div import fihos_pkg::*; #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_req_t             req,
	output logic                      done,
	output logic [FRAC_BITS-1:0]      quot
);

	localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

	logic [DUR_BITS-1:0]  rem_q;
	logic [DUR_BITS-1:0]  den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DUR_BITS:0]    trial;
	logic                 fits;

	// remainder stays below the divisor, so one spare bit holds the shifted trial
	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DUR_BITS'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DUR_BITS-1:0];
			end
			quot_q <= {quot_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// File: tb/sv/tb_fade_in_hold_out_sequencer_top.sv
`timescale 1ns / 100ps

module tb_fade_in_hold_out_sequencer_top;
	import fihos_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int         FRAC_BITS  = 15;
	localparam logic [15:0] LEVEL_FULL = 16'(1 << FRAC_BITS);

	typedef enum logic [2:0] {
		RAMP_START, RAMP_SETTLE, RAMP_FADE_IN, RAMP_HOLD, RAMP_FADE_OUT, RAMP_DONE
	} ramp_phase_t;

	typedef struct packed {
		logic        level_set;
		logic [15:0] level;
		ramp_phase_t phase_after;
	} fade_result_t;

	typedef enum logic {ROW_WRITE, ROW_REFRESH} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_sel;
		logic [15:0] reg_val;
		logic [31:0] stamp;
		logic        skip;
		logic        typed;
		logic        exp_set;
		logic [15:0] exp_level;
		ramp_phase_t exp_phase;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 15;

	// opening walk: start with no fade-in, settle, time stamp wrap, zero step,
	// skip flag during the ramp and fade-in length changed mid-ramp
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{ROW_WRITE,   REG_FADE_IN,  16'h0000, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_WRITE,   REG_FADE_OUT, 16'h0000, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_WRITE,   REG_HOLD,     16'h0000, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_WRITE,   REG_UNUSED,   16'hffff, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'hffff_fff0, 1'b0, 1'b1, 1'b0, 16'h0, RAMP_SETTLE},
		'{ROW_WRITE,   REG_FADE_IN,  16'hffff, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'hffff_fff8, 1'b0, 1'b1, 1'b1, 16'h0, RAMP_FADE_IN},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_00f8, 1'b0, 1'b1, 1'b1, 16'h0, RAMP_FADE_IN},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_00f8, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_01f7, 1'b1, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_WRITE,   REG_FADE_IN,  16'd1024, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_0207, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_0307, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_WRITE,   REG_FADE_IN,  16'hffff, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0, RAMP_START},
		'{ROW_REFRESH, REG_FADE_IN,  16'h0, 32'h0000_0407, 1'b1, 1'b0, 1'b0, 16'h0, RAMP_START}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_index = '0;
	logic [DUR_BITS-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [31:0]         now_ms    = '0;
	logic                skip_hold = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                level_valid;
	logic [15:0]         fade_level;
	logic [2:0]          phase_now;

	// predictor state
	ramp_phase_t  cur_phase    = RAMP_START;
	logic [31:0]  last_stamp   = '0;
	logic [31:0]  elapsed_ms   = '0;
	logic         hold_skipped = 1'b0;
	logic [15:0]  fade_in_dur  = '0;
	logic [15:0]  fade_out_dur = '0;
	logic [15:0]  hold_dur     = '0;
	fade_result_t expected_levels[$];

	logic [31:0] stamp_ms      = '0;
	int          idle_pct      = 0;
	int          stall_pct     = 0;
	int          chunk_no      = 0;
	int          mismatches    = 0;
	int          refreshes     = 0;
	int          results_seen  = 0;
	int          levels_seen   = 0;
	int          writes_done   = 0;

	fade_in_hold_out_sequencer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.skip_hold  (skip_hold),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.level_valid(level_valid),
		.fade_level (fade_level),
		.phase_now  (phase_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] add_capped(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[32] ? '1 : sum[31:0];
	endfunction

	function automatic logic [15:0] ramp_fraction(input logic [31:0] num, input logic [15:0] den);
		logic [63:0] scaled;
		scaled = {32'b0, num} << FRAC_BITS;
		return 16'(scaled / {48'b0, den});
	endfunction

	task automatic predict_level(input logic [31:0] stamp, input logic skip);
		logic [31:0]  dt;
		logic [15:0]  hold_eff;
		fade_result_t r;
		dt = '0;
		r  = '0;
		if (skip)
			hold_skipped = 1'b1;
		hold_eff = hold_skipped ? 16'h0 : hold_dur;
		if (cur_phase == RAMP_START) begin
			last_stamp = stamp;
		end else if (cur_phase >= RAMP_SETTLE && cur_phase <= RAMP_FADE_OUT) begin
			dt = stamp - last_stamp;
			last_stamp = stamp;
		end
		case (cur_phase)
			RAMP_START, RAMP_SETTLE: begin
				r.level_set = (fade_in_dur != 0);
				elapsed_ms = '0;
				cur_phase = (cur_phase == RAMP_START) ? RAMP_SETTLE : RAMP_FADE_IN;
			end
			RAMP_FADE_IN: begin
				r.level_set = 1'b1;
				if (elapsed_ms < {16'b0, fade_in_dur}) begin
					r.level = ramp_fraction(elapsed_ms, fade_in_dur);
					elapsed_ms = add_capped(elapsed_ms, dt);
				end else begin
					r.level = LEVEL_FULL;
					elapsed_ms = '0;
					cur_phase = RAMP_HOLD;
				end
			end
			RAMP_HOLD: begin
				if (elapsed_ms < {16'b0, hold_eff}) begin
					elapsed_ms = add_capped(elapsed_ms, dt);
				end else begin
					elapsed_ms = '0;
					cur_phase = RAMP_FADE_OUT;
				end
			end
			RAMP_FADE_OUT: begin
				r.level_set = 1'b1;
				if (fade_out_dur == 0) begin
					r.level = LEVEL_FULL;
					elapsed_ms = '0;
					cur_phase = RAMP_DONE;
				end else if (elapsed_ms < {16'b0, fade_out_dur}) begin
					r.level = LEVEL_FULL - ramp_fraction(elapsed_ms, fade_out_dur);
					elapsed_ms = add_capped(elapsed_ms, dt);
				end else begin
					r.level = '0;
					elapsed_ms = '0;
					cur_phase = RAMP_DONE;
				end
			end
			default: ;
		endcase
		r.phase_after = cur_phase;
		expected_levels.push_back(r);
	endtask

	// one request, presented after a random gap, held until taken
	task automatic push_refresh(input logic [31:0] stamp, input logic skip);
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		now_ms    <= stamp;
		skip_hold <= skip;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		predict_level(stamp, skip);
		refreshes++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		cfg_we   <= 1'b0;
		do
			@(posedge clk);
		while (expected_levels.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		case (sel)
			REG_FADE_IN:  fade_in_dur = val;
			REG_FADE_OUT: fade_out_dur = val;
			REG_HOLD: begin
				hold_dur = val;
				hold_skipped = 1'b0;
			end
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic step_refresh(input int lo, input int hi, input int skip_permille);
		stamp_ms = stamp_ms + 32'($urandom_range(lo, hi));
		push_refresh(stamp_ms, $urandom_range(0, 999) < skip_permille);
	endtask

	// a run of requests under one idling mode; scatter sends arbitrary stamps
	task automatic run_chunk(input int n, input int hi, input int skip_permille,
			input logic scatter);
		case (chunk_no % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 73; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 73; end
			default: begin idle_pct = 24; stall_pct = 24; end
		endcase
		chunk_no++;
		repeat (n) begin
			if (scatter) begin
				stamp_ms = $urandom;
				push_refresh(stamp_ms, 1'($urandom_range(0, 1)));
			end else begin
				step_refresh(0, hi, skip_permille);
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_levels.size() == 0) begin
				$error("result with no request waiting: level_valid %0d fade_level %0d phase %0d",
					level_valid, fade_level, phase_now);
				mismatches++;
			end else begin
				fade_result_t e;
				e = expected_levels.pop_front();
				results_seen++;
				if (e.level_set)
					levels_seen++;
				if (level_valid !== e.level_set) begin
					$error("level_valid: expected %0d, got %0d", e.level_set, level_valid);
					mismatches++;
				end
				if (fade_level !== e.level) begin
					$error("fade_level: expected %0d, got %0d", e.level, fade_level);
					mismatches++;
				end
				if (phase_now !== e.phase_after) begin
					$error("phase_now: expected %0d, got %0d", e.phase_after, phase_now);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("fade_in_hold_out_sequencer_top regression: fail");
		$finish;
	end

	initial begin
		stim_row_t row;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				quiesce();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				push_refresh(row.stamp, row.skip);
				if (row.typed)
					expected_levels[expected_levels.size() - 1] =
						'{row.exp_set, row.exp_level, row.exp_phase};
				stamp_ms = row.stamp;
			end
		end

		// long fade-in ramp, lengths changed between runs
		for (int c = 0; c < 4; c++) begin
			quiesce();
			write_reg(REG_FADE_IN, (c == 0) ? 16'hffff : 16'($urandom_range(40000, 65535)));
			write_reg(REG_FADE_OUT, ($urandom_range(0, 1) != 0) ? 16'h0 : 16'($urandom));
			write_reg(REG_HOLD, 16'($urandom));
			run_chunk(100, 100, 20, 1'b0);
		end
		while (cur_phase == RAMP_FADE_IN)
			step_refresh(1000, 4000, 0);

		// hold, left by skip request or by a saturating backward step
		quiesce();
		write_reg(REG_HOLD, 16'hffff);
		write_reg(REG_FADE_OUT, 16'($urandom_range(32000, 65535)));
		run_chunk(100, 100, 5, 1'b0);
		quiesce();
		write_reg(REG_HOLD, 16'($urandom_range(20000, 65535)));
		run_chunk(100, 100, 5, 1'b0);
		if (cur_phase == RAMP_HOLD) begin
			stamp_ms = stamp_ms - 32'd1;
			push_refresh(stamp_ms, 1'b0);
		end
		while (cur_phase == RAMP_HOLD)
			step_refresh(1, 1, 0);

		// fade-out ramp
		for (int c = 0; c < 3; c++) begin
			quiesce();
			write_reg(REG_FADE_OUT, (c == 0) ? 16'hffff : 16'($urandom_range(32000, 65535)));
			run_chunk(100, 100, 5, 1'b0);
		end
		if ($urandom_range(0, 1) != 0) begin
			// zero fade-out ends at full level
			quiesce();
			write_reg(REG_FADE_OUT, 16'h0);
			step_refresh(0, 100, 0);
		end else if (cur_phase == RAMP_FADE_OUT) begin
			stamp_ms = stamp_ms - 32'd1;
			push_refresh(stamp_ms, 1'b0);
		end
		while (cur_phase == RAMP_FADE_OUT)
			step_refresh(1, 1, 0);

		// done phase holds whatever arrives
		for (int c = 0; c < 2; c++) begin
			quiesce();
			write_reg(2'($urandom_range(0, 3)), 16'($urandom));
			run_chunk(50, 0, 0, 1'b1);
		end

		quiesce();
		repeat (20) @(posedge clk);
		$display("covered %0d refreshes through every phase to done, %0d register writes",
			refreshes, writes_done);
		$display("checked %0d results, %0d of them setting a level", results_seen, levels_seen);
		if (mismatches == 0)
			$display("fade_in_hold_out_sequencer_top regression: pass");
		else
			$display("fade_in_hold_out_sequencer_top regression: fail");
		$finish;
	end

endmodule

// File: fade_in_hold_out_sequencer_top.f
sv/fihos_pkg.sv
sv/fihos_div.sv
sv/fade_in_hold_out_sequencer_top.sv
tb/sv/tb_fade_in_hold_out_sequencer_top.sv
